// File: rtl/core/nfrl_pkg.sv
`timescale 1ns / 1ps

package nfrl_pkg;

  localparam int CAPACITY_DEF = 16;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_READ   = 3'd3,
    CMD_INIT   = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  kind;
    logic        time_valid;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] title_handle;
    logic [15:0] message_handle;
    logic [31:0] target_id;
    logic [3:0]  read_index;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [4:0]  entry_count;
    logic [31:0] generation;
    logic [31:0] rec_id;
    logic [3:0]  rec_kind;
    logic [4:0]  rec_hour;
    logic [5:0]  rec_minute;
    logic [15:0] rec_title;
    logic [15:0] rec_message;
  } rsp_t;

  typedef struct packed {
    logic [31:0] id;
    logic [3:0]  kind;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] title;
    logic [15:0] message;
  } rec_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctl_t;

endpackage

// File: rtl/core/newest_first_record_list.sv
`timescale 1ns / 1ps

// Bounded list of records kept newest first, driven by one command per transfer.
// The request channel (req_valid, req_ready, req) carries push, remove by id,
// clear all, read by index and init. The response channel (rsp_valid,
// rsp_ready, rsp) returns exactly one result per request: status, entry count,
// generation and, for a successful read, the record fields.
// Each command has an accept step, where the remove id is compared against every
// live id in parallel, and an execute step, where a push shifts the whole chain
// at once and a remove shifts only the entries past the match. The response is
// registered in the execute step; no new request is taken before that step ends.
// The response sits in an output register; a new request is accepted while it
// waits. If the receiver stalls, the next command holds in its execute step
// until the waiting response is taken.
// Reset empties the list, sets the next id and the generation to one, and
// drops any pending response. Entries past the current count hold stale data
// that is never returned.
module newest_first_record_list #(
  parameter int CAPACITY = nfrl_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  nfrl_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output nfrl_pkg::rsp_t rsp
);

  nfrl_pkg::ctl_t ctl;

  nfrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .ctl       (ctl)
  );

  nfrl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .req (req),
    .rsp (rsp)
  );

endmodule

// File: rtl/core/nfrl_ctrl.sv
`timescale 1ns / 1ps

module nfrl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output nfrl_pkg::ctl_t ctl
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  assign req_ready   = !rst && (state == S_IDLE);
  assign ctl.capture = req_valid && !rst && (state == S_IDLE);
  assign ctl.commit  = (state == S_EXEC) && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EXEC;
          end
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
          end
        end
        S_EXEC: begin
          if (ctl.commit) begin
            state     <= S_IDLE;
            rsp_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/nfrl_datapath.sv
`timescale 1ns / 1ps

module nfrl_datapath #(
  parameter int CAPACITY = nfrl_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  nfrl_pkg::ctl_t ctl,
  input  nfrl_pkg::req_t req,
  output nfrl_pkg::rsp_t rsp
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IDXW = $clog2(CAPACITY);
  localparam int CMPW = (CW > 4) ? CW : 4;

  nfrl_pkg::rec_t entries [CAPACITY];
  nfrl_pkg::rec_t entries_next [CAPACITY];
  nfrl_pkg::rec_t new_rec;
  nfrl_pkg::req_t req_q;
  nfrl_pkg::rsp_t rsp_next;

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [31:0]         next_id;
  logic [31:0]         next_id_next;
  logic [31:0]         gen;
  logic [31:0]         gen_next;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] match_q;
  logic [CAPACITY-1:0] after;
  logic                found;
  logic                rd_hit;
  logic [IDXW-1:0]     rd_idx;

  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      match[j] = (entries[j].id == req.target_id) && (CW'(j) < count);
    end
  end

  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      after[j] = |(match_q & ({CAPACITY{1'b1}} >> (CAPACITY - 1 - j)));
    end
  end

  assign found  = |match_q;
  assign rd_hit = (CMPW'(req_q.read_index) < CMPW'(count));
  assign rd_idx = IDXW'(req_q.read_index);

  always_comb begin
    new_rec         = '0;
    new_rec.id      = next_id;
    new_rec.kind    = req_q.kind;
    new_rec.title   = req_q.title_handle;
    new_rec.message = req_q.message_handle;
    if (req_q.time_valid) begin
      new_rec.hour   = req_q.hour;
      new_rec.minute = req_q.minute;
    end
  end

  always_comb begin
    entries_next = entries;
    count_next   = count;
    next_id_next = next_id;
    gen_next     = gen;
    rsp_next     = '0;
    unique case (req_q.command)
      nfrl_pkg::CMD_PUSH: begin
        for (int j = CAPACITY - 1; j > 0; j--) begin
          entries_next[j] = entries[j-1];
        end
        entries_next[0] = new_rec;
        if (count != CW'(CAPACITY)) begin
          count_next = count + CW'(1);
        end
        next_id_next = (next_id == '1) ? 32'd1 : next_id + 32'd1;
        gen_next     = gen + 32'd1;
        rsp_next.ok  = 1'b1;
      end
      nfrl_pkg::CMD_REMOVE: begin
        if (found) begin
          for (int j = 0; j < CAPACITY - 1; j++) begin
            if (after[j]) begin
              entries_next[j] = entries[j+1];
            end
          end
          count_next  = count - CW'(1);
          gen_next    = gen + 32'd1;
          rsp_next.ok = 1'b1;
        end
      end
      nfrl_pkg::CMD_CLEAR: begin
        if (count != '0) begin
          count_next = '0;
          gen_next   = gen + 32'd1;
        end
        rsp_next.ok = 1'b1;
      end
      nfrl_pkg::CMD_READ: begin
        if (rd_hit) begin
          rsp_next.ok          = 1'b1;
          rsp_next.rec_id      = entries[rd_idx].id;
          rsp_next.rec_kind    = entries[rd_idx].kind;
          rsp_next.rec_hour    = entries[rd_idx].hour;
          rsp_next.rec_minute  = entries[rd_idx].minute;
          rsp_next.rec_title   = entries[rd_idx].title;
          rsp_next.rec_message = entries[rd_idx].message;
        end
      end
      nfrl_pkg::CMD_INIT: begin
        count_next   = '0;
        next_id_next = 32'd1;
        gen_next     = gen + 32'd1;
        rsp_next.ok  = 1'b1;
      end
      default: begin
      end
    endcase
    rsp_next.entry_count = 5'(count_next);
    rsp_next.generation  = gen_next;
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req_q   <= req;
      match_q <= match;
    end
    if (ctl.commit) begin
      entries <= entries_next;
      rsp     <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      next_id <= 32'd1;
      gen     <= 32'd1;
    end else if (ctl.commit) begin
      count   <= count_next;
      next_id <= next_id_next;
      gen     <= gen_next;
    end
  end

endmodule

// File: rtl/core/nfrl_checker.sv
`timescale 1ns / 1ps

module nfrl_checker #(
  parameter int CAPACITY = nfrl_pkg::CAPACITY_DEF
) (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input nfrl_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input nfrl_pkg::rsp_t rsp
);

  a_reset_drops_rsp: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while a command executes");

  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> rsp.rec_id == 32'd0 && rsp.rec_kind == 4'd0 &&
      rsp.rec_hour == 5'd0 && rsp.rec_minute == 6'd0 &&
      rsp.rec_title == 16'd0 && rsp.rec_message == 16'd0)
    else $error("record fields set on a failed command");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (CAPACITY > 31) || (rsp.entry_count <= 5'(CAPACITY)))
    else $error("entry count above capacity");

endmodule

bind newest_first_record_list nfrl_checker #(.CAPACITY(CAPACITY)) u_nfrl_checker (.*);

// File: sim/newest_first_record_list_tb.sv
`timescale 1ns / 1ps

module newest_first_record_list_tb;

  localparam int LIST_DEPTH = nfrl_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 550;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic drain_first;
    nfrl_pkg::req_t req;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  nfrl_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  nfrl_pkg::rsp_t rsp;

  pending_t cmd_queue[$];
  nfrl_pkg::rsp_t awaited_rsp[$];
  nfrl_pkg::rsp_t want_rsp;
  logic req_taken = 1'b0;
  int send_gap = 0;
  int send_quiet = 0;
  int stall_left = 0;
  int recv_quiet = 0;
  int mismatch_count = 0;
  logic [31:0] gen_next_id = 32'd1;

  nfrl_pkg::rec_t list_recs [LIST_DEPTH] = '{default: '0};
  int list_len = 0;
  logic [31:0] id_counter = 32'd1;
  logic [31:0] gen_count = 32'd1;

  newest_first_record_list u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic nfrl_pkg::rsp_t apply_command(nfrl_pkg::req_t r);
    nfrl_pkg::rsp_t o;
    int i;
    int hit;
    o = '0;
    case (r.command)
      nfrl_pkg::CMD_PUSH: begin
        if (list_len < LIST_DEPTH) list_len++;
        for (i = list_len - 1; i > 0; i--) list_recs[i] = list_recs[i - 1];
        list_recs[0] = '0;
        list_recs[0].id = id_counter;
        list_recs[0].kind = r.kind;
        if (r.time_valid) begin
          list_recs[0].hour = r.hour;
          list_recs[0].minute = r.minute;
        end
        list_recs[0].title = r.title_handle;
        list_recs[0].message = r.message_handle;
        id_counter++;
        if (id_counter == '0) id_counter = 32'd1;
        gen_count++;
        o.ok = 1'b1;
      end
      nfrl_pkg::CMD_REMOVE: begin
        hit = -1;
        for (i = 0; i < list_len; i++) begin
          if (hit < 0 && list_recs[i].id == r.target_id) hit = i;
        end
        if (hit >= 0) begin
          for (i = hit; i + 1 < list_len; i++) list_recs[i] = list_recs[i + 1];
          list_len--;
          list_recs[list_len] = '0;
          gen_count++;
          o.ok = 1'b1;
        end
      end
      nfrl_pkg::CMD_CLEAR: begin
        if (list_len != 0) begin
          foreach (list_recs[k]) list_recs[k] = '0;
          list_len = 0;
          gen_count++;
        end
        o.ok = 1'b1;
      end
      nfrl_pkg::CMD_READ: begin
        if (r.read_index < list_len) begin
          o.ok = 1'b1;
          o.rec_id = list_recs[r.read_index].id;
          o.rec_kind = list_recs[r.read_index].kind;
          o.rec_hour = list_recs[r.read_index].hour;
          o.rec_minute = list_recs[r.read_index].minute;
          o.rec_title = list_recs[r.read_index].title;
          o.rec_message = list_recs[r.read_index].message;
        end
      end
      nfrl_pkg::CMD_INIT: begin
        foreach (list_recs[k]) list_recs[k] = '0;
        list_len = 0;
        id_counter = 32'd1;
        gen_count++;
        o.ok = 1'b1;
      end
      default: ;
    endcase
    o.entry_count = 5'(list_len);
    o.generation = gen_count;
    return o;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic nfrl_pkg::req_t random_req(input logic [2:0] op);
    nfrl_pkg::req_t r;
    r.command = op;
    r.kind = 4'($urandom_range(0, 15));
    r.time_valid = 1'($urandom_range(0, 1));
    r.hour = 5'($urandom_range(0, 31));
    r.minute = 6'($urandom_range(0, 63));
    r.title_handle = 16'($urandom_range(0, 65535));
    r.message_handle = 16'($urandom_range(0, 65535));
    r.target_id = $urandom;
    r.read_index = 4'($urandom_range(0, 15));
    return r;
  endfunction

  // Most removes aim at ids pushed recently, so many of them hit a live entry.
  function automatic logic [31:0] pick_target();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return gen_next_id - $urandom_range(1, 24);
    if (roll < 85) return $urandom;
    if (roll < 95) return '0;
    return gen_next_id;
  endfunction

  task automatic queue_req(input nfrl_pkg::req_t r, input bit drain);
    pending_t p;
    p.drain_first = drain;
    p.req = r;
    cmd_queue.push_back(p);
    if (r.command == nfrl_pkg::CMD_PUSH) gen_next_id++;
    if (r.command == nfrl_pkg::CMD_INIT) gen_next_id = 32'd1;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap <= 0;
    end else if (!req_valid || req_taken) begin
      if (send_gap > 0) begin
        req_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (cmd_queue.size() != 0 &&
                   (!cmd_queue[0].drain_first || awaited_rsp.size() == 0)) begin
        req <= cmd_queue[0].req;
        req_valid <= 1'b1;
        cmd_queue.pop_front();
        send_gap <= pick_gap(send_quiet != 0);
        if (send_quiet != 0) send_quiet <= send_quiet - 1;
        else if ($urandom_range(0, 19) == 0) send_quiet <= $urandom_range(15, 40);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      rsp_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp_ready <= 1'b1;
      stall_left <= pick_gap(recv_quiet != 0);
      if (recv_quiet != 0) recv_quiet <= recv_quiet - 1;
      else if ($urandom_range(0, 19) == 0) recv_quiet <= $urandom_range(15, 40);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && req_ready;
      if (req_valid && req_ready) awaited_rsp.push_back(apply_command(req));
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: response transfer with none expected, got %h", $realtime, rsp);
        end else begin
          want_rsp = awaited_rsp.pop_front();
          check_field("ok", 32'(want_rsp.ok), 32'(rsp.ok));
          check_field("entry_count", 32'(want_rsp.entry_count), 32'(rsp.entry_count));
          check_field("generation", want_rsp.generation, rsp.generation);
          check_field("rec_id", want_rsp.rec_id, rsp.rec_id);
          check_field("rec_kind", 32'(want_rsp.rec_kind), 32'(rsp.rec_kind));
          check_field("rec_hour", 32'(want_rsp.rec_hour), 32'(rsp.rec_hour));
          check_field("rec_minute", 32'(want_rsp.rec_minute), 32'(rsp.rec_minute));
          check_field("rec_title", 32'(want_rsp.rec_title), 32'(rsp.rec_title));
          check_field("rec_message", 32'(want_rsp.rec_message), 32'(rsp.rec_message));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[newest_first_record_list] ERROR");
    $finish;
  end

  initial begin
    nfrl_pkg::req_t r;
    int roll;
    int random_count;
    int op;
    bit drain;

    r = random_req(nfrl_pkg::CMD_READ);
    r.read_index = 4'd0;
    queue_req(r, 1'b0);
    r = random_req(nfrl_pkg::CMD_REMOVE);
    r.target_id = '0;
    queue_req(r, 1'b0);
    queue_req(random_req(nfrl_pkg::CMD_CLEAR), 1'b0);
    r = random_req(nfrl_pkg::CMD_PUSH);
    r.kind = 4'hF;
    r.time_valid = 1'b0;
    r.hour = 5'd17;
    r.minute = 6'd42;
    r.title_handle = 16'hFFFF;
    r.message_handle = 16'hFFFF;
    queue_req(r, 1'b0);
    r = random_req(nfrl_pkg::CMD_PUSH);
    r.kind = 4'h0;
    r.time_valid = 1'b1;
    r.hour = 5'd23;
    r.minute = 6'd59;
    r.title_handle = 16'h0000;
    r.message_handle = 16'h0000;
    queue_req(r, 1'b0);
    r = random_req(nfrl_pkg::CMD_PUSH);
    r.time_valid = 1'b1;
    r.hour = 5'd31;
    r.minute = 6'd63;
    queue_req(r, 1'b0);
    for (op = 0; op < 4; op++) begin
      r = random_req(nfrl_pkg::CMD_READ);
      r.read_index = 4'(op);
      queue_req(r, 1'b0);
    end
    r = random_req(nfrl_pkg::CMD_REMOVE);
    r.target_id = 32'd2;
    queue_req(r, 1'b0);
    queue_req(r, 1'b0);
    r.target_id = 32'hFFFF_FFFF;
    queue_req(r, 1'b0);
    r = random_req(nfrl_pkg::CMD_READ);
    r.read_index = 4'd15;
    queue_req(r, 1'b0);
    for (op = CMD_UNUSED_LO; op <= CMD_UNUSED_HI; op++) queue_req(random_req(3'(op)), 1'b0);
    queue_req(random_req(nfrl_pkg::CMD_CLEAR), 1'b0);
    queue_req(random_req(nfrl_pkg::CMD_CLEAR), 1'b0);
    queue_req(random_req(nfrl_pkg::CMD_PUSH), 1'b0);
    queue_req(random_req(nfrl_pkg::CMD_INIT), 1'b0);
    queue_req(random_req(nfrl_pkg::CMD_PUSH), 1'b0);
    r = random_req(nfrl_pkg::CMD_READ);
    r.read_index = 4'd0;
    queue_req(r, 1'b0);

    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      drain = (random_count % 120 == 0);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        repeat ($urandom_range(LIST_DEPTH, LIST_DEPTH + 4)) begin
          queue_req(random_req(nfrl_pkg::CMD_PUSH), drain);
          drain = 1'b0;
          random_count++;
        end
      end else begin
        if (roll < 40) op = nfrl_pkg::CMD_PUSH;
        else if (roll < 62) op = nfrl_pkg::CMD_REMOVE;
        else if (roll < 90) op = nfrl_pkg::CMD_READ;
        else if (roll < 93) op = nfrl_pkg::CMD_CLEAR;
        else if (roll < 95) op = nfrl_pkg::CMD_INIT;
        else op = $urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI);
        r = random_req(3'(op));
        if (op == nfrl_pkg::CMD_REMOVE) r.target_id = pick_target();
        queue_req(r, drain);
        random_count++;
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() != 0 || req_valid || awaited_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
      $display("[newest_first_record_list] OK");
    end else begin
      $display("[newest_first_record_list] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/nfrl_pkg.sv
rtl/core/nfrl_ctrl.sv
rtl/core/nfrl_datapath.sv
rtl/core/newest_first_record_list.sv
rtl/core/nfrl_checker.sv
sim/newest_first_record_list_tb.sv
